@@ sv/ucfp_pkg.sv @@
// ----------------------------------------------------------------------------
// ucfp_pkg
// Types, codes and length tables of the UART command frame parser.
// ----------------------------------------------------------------------------
package ucfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 10;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LenW-1:0] LenBulk     = LenW'(513);
  localparam logic [LenW-1:0] LenBlock    = LenW'(129);
  localparam logic [LenW-1:0] LenParamSet = LenW'(9 + 128);
  localparam logic [LenW-1:0] LenTriplet  = LenW'(3 * 2 * 2 + 1);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_IGNORED  = 3'd0,
    ST_STARTED  = 3'd1,
    ST_PASSED   = 3'd2,
    ST_COMPLETE = 3'd3,
    ST_TAILERR  = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEAD = 2'd0,
    REG_TAIL = 2'd1,
    REG_ROLE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ByteW-1:0] head_byte;
    logic [ByteW-1:0] tail_byte;
    logic             frame_role;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  frame_length;
  } result_t;

  // zero marks an unknown command
  function automatic logic [LenW-1:0] host_len(input logic [ByteW-1:0] c);
    logic [LenW-1:0] len;
    case (c)
      8'h30, 8'h31, 8'h40, 8'h41:        len = LenW'(1);
      8'h42, 8'hC0:                      len = LenW'(2);
      8'h51:                             len = LenBlock;
      8'h90, 8'h91, 8'h92:               len = LenBulk;
      8'h93:                             len = LenW'(17);
      8'hAD:                             len = LenParamSet;
      8'hB0:                             len = LenW'(3);
      8'hB1:                             len = LenW'(25);
      8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4: len = LenBulk;
      default:                           len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [LenW-1:0] device_len(input logic [ByteW-1:0] c);
    logic [LenW-1:0] len;
    case (c)
      8'h01, 8'h02, 8'h03:                      len = LenBulk;
      8'h11, 8'h42, 8'h83, 8'h93, 8'hAB, 8'hAC: len = LenW'(2);
      8'h12:                                    len = LenW'(5);
      8'h13, 8'hB0:                             len = LenW'(3);
      8'h14:                                    len = LenW'(6);
      8'h20, 8'h21:                             len = LenW'(21);
      8'h22, 8'h23, 8'hB1:                      len = LenW'(25);
      8'hAD:                                    len = LenParamSet;
      8'hD1:                                    len = LenTriplet;
      8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4:        len = LenBulk;
      default:                                  len = LenW'(1);
    endcase
    return len;
  endfunction

endpackage

@@ sv/ucfp_if.sv @@
// ----------------------------------------------------------------------------
// ucfp channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface ucfp_rx_if;
  import ucfp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfp_res_if;
  import ucfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   data_byte;
  logic [LenW-1:0]    frame_length;

  modport source (output valid, output status, output data_byte, output frame_length,
                  input ready);
  modport sink   (input valid, input status, input data_byte, input frame_length,
                  output ready);
endinterface

interface ucfp_cfg_if;
  import ucfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/ucfp_len_lut.sv @@
// ----------------------------------------------------------------------------
// ucfp_len_lut
// Frame length lookup for a command byte, by role.
// ----------------------------------------------------------------------------
module ucfp_len_lut (
  input  logic [ucfp_pkg::ByteW-1:0] cmd_byte_i,
  input  logic                       frame_role_i,
  output logic [ucfp_pkg::LenW-1:0]  frame_len_o,
  output logic                       known_o
);
  import ucfp_pkg::*;

  always_comb begin
    if (frame_role_i) begin
      frame_len_o = device_len(cmd_byte_i);
    end else begin
      frame_len_o = host_len(cmd_byte_i);
    end
    known_o = (frame_len_o != '0);
  end

endmodule

@@ sv/ucfp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ucfp_cfg_regs
// Head, tail and role registers behind the configuration channel.
// ----------------------------------------------------------------------------
module ucfp_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  ucfp_cfg_if.sink         cfg_i,
  output ucfp_pkg::cfg_t   cfg_o
);
  import ucfp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_HEAD: cfg_d.head_byte  = cfg_i.data;
        REG_TAIL: cfg_d.tail_byte  = cfg_i.data;
        REG_ROLE: cfg_d.frame_role = cfg_i.data[0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ sv/ucfp_fsm.sv @@
// ----------------------------------------------------------------------------
// ucfp_fsm
// Frame phase tracking and per-byte result generation.
// ----------------------------------------------------------------------------
module ucfp_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [ucfp_pkg::ByteW-1:0] rx_byte_i,
  input  ucfp_pkg::cfg_t             cfg_i,
  output ucfp_pkg::result_t          result_o
);
  import ucfp_pkg::*;

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] remain_q, remain_d;
  logic [LenW-1:0] lut_len;
  logic            lut_known;
  logic [LenW-1:0] remain_dec;

  ucfp_len_lut u_len_lut (
    .cmd_byte_i   (rx_byte_i),
    .frame_role_i (cfg_i.frame_role),
    .frame_len_o  (lut_len),
    .known_o      (lut_known)
  );

  assign remain_dec = (remain_q != '0) ? remain_q - LenW'(1) : remain_q;

  always_comb begin
    phase_d  = phase_q;
    remain_d = remain_q;
    result_o = '{status: ST_IGNORED, data_byte: '0, frame_length: '0};
    case (phase_q)
      PH_IDLE: begin
        if (rx_byte_i == cfg_i.head_byte) begin
          result_o.status = ST_STARTED;
          phase_d         = PH_CMD;
        end
      end
      PH_CMD: begin
        if (!lut_known) begin
          result_o.status = ST_UNKNOWN;
          phase_d         = PH_IDLE;
          remain_d        = '0;
        end else begin
          result_o.status       = ST_PASSED;
          result_o.data_byte    = rx_byte_i;
          result_o.frame_length = lut_len;
          remain_d              = lut_len - LenW'(1);
          phase_d               = (lut_len == LenW'(1)) ? PH_TAIL : PH_DATA;
        end
      end
      PH_DATA: begin
        result_o.status    = ST_PASSED;
        result_o.data_byte = rx_byte_i;
        remain_d           = remain_dec;
        if (remain_dec == '0) begin
          phase_d = PH_TAIL;
        end
      end
      PH_TAIL: begin
        result_o.status = (rx_byte_i == cfg_i.tail_byte) ? ST_COMPLETE : ST_TAILERR;
        phase_d         = PH_IDLE;
        remain_d        = '0;
      end
      default: begin
        phase_d  = PH_IDLE;
        remain_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      remain_q <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
    end
  end

endmodule

@@ sv/uart_command_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// uart_command_frame_parser_core
// Head / command / payload / tail deframer for received UART bytes.
// ----------------------------------------------------------------------------
// Bytes enter on rx_i, one per transaction; every byte yields exactly one
// result transaction on res_o (status, data_byte, frame_length). Register
// writes on cfg_i set the head byte, tail byte and role (host or device
// length table); cfg_i is always ready. The user must write cfg_i only
// while idle; the block does not enforce this. A byte is held in an
// input register, then decoded against the phase and the command length
// table into the result register that drives res_o. A new byte is taken
// every cycle while res_o does not stall. When res_o stalls, the input
// register keeps its byte and rx_i stays ready while that register is
// free, so one byte waits behind the held result. Reset clears the valid
// bits of both pipeline registers, returns the parser to idle with no
// payload pending and clears the head, tail and role registers to zero.
// ----------------------------------------------------------------------------
module uart_command_frame_parser_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ucfp_rx_if.sink   rx_i,
  ucfp_cfg_if.sink  cfg_i,
  ucfp_res_if.source res_o
);
  import ucfp_pkg::*;

  cfg_t             cfg;
  result_t          result;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             out_load;
  logic             in_load;

  ucfp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ucfp_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (out_load),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign out_load   = in_valid_q && (!out_valid_q || res_o.ready);
  assign in_load    = rx_i.valid && rx_i.ready;
  assign rx_i.ready = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = out_q.status;
  assign res_o.data_byte    = out_q.data_byte;
  assign res_o.frame_length = out_q.frame_length;

endmodule

@@ tb/sv/ucfp_frame_checker.sv @@
// ----------------------------------------------------------------------------
// ucfp_frame_checker
// Watches the byte, register and result channels of the frame parser.
// Tracks head, tail and role from accepted register writes, deframes every
// accepted byte into its outcome (status, data byte, frame length) and
// compares each accepted result transaction with the oldest outcome still
// owed.
// ----------------------------------------------------------------------------
module ucfp_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucfp_rx_if          rx_i,
  ucfp_cfg_if         cfg_i,
  ucfp_res_if         res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned frames_ok_o,
  output int unsigned tail_errors_o,
  output int unsigned unknown_cmds_o
);
  import ucfp_pkg::*;

  cfg_t            regs;
  phase_e          phase;
  logic [LenW-1:0] remaining;
  result_t         byte_outcomes[$];
  int unsigned     fails;
  int unsigned     frames_ok;
  int unsigned     tail_errors;
  int unsigned     unknown_cmds;

  function automatic logic [LenW-1:0] host_frame_len(input logic [ByteW-1:0] c);
    case (c)
      8'h30, 8'h31, 8'h40, 8'h41:        return 10'd1;
      8'h42, 8'hC0:                      return 10'd2;
      8'h51:                             return 10'd129;
      8'h90, 8'h91, 8'h92:               return 10'd513;
      8'h93:                             return 10'd17;
      8'hAD:                             return 10'd137;
      8'hB0:                             return 10'd3;
      8'hB1:                             return 10'd25;
      8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4: return 10'd513;
      default:                           return 10'd0;
    endcase
  endfunction

  function automatic logic [LenW-1:0] device_frame_len(input logic [ByteW-1:0] c);
    case (c)
      8'h01, 8'h02, 8'h03:                      return 10'd513;
      8'h11, 8'h42, 8'h83, 8'h93, 8'hAB, 8'hAC: return 10'd2;
      8'h12:                                    return 10'd5;
      8'h13, 8'hB0:                             return 10'd3;
      8'h14:                                    return 10'd6;
      8'h20, 8'h21:                             return 10'd21;
      8'h22, 8'h23, 8'hB1:                      return 10'd25;
      8'hAD:                                    return 10'd137;
      8'hD1:                                    return 10'd13;
      8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4:        return 10'd513;
      default:                                  return 10'd1;
    endcase
  endfunction

  function automatic result_t deframe(input logic [ByteW-1:0] b);
    result_t         r;
    logic [LenW-1:0] len;
    r.status       = ST_IGNORED;
    r.data_byte    = '0;
    r.frame_length = '0;
    case (phase)
      PH_IDLE: begin
        if (b == regs.head_byte) begin
          r.status = ST_STARTED;
          phase    = PH_CMD;
        end
      end
      PH_CMD: begin
        len = regs.frame_role ? device_frame_len(b) : host_frame_len(b);
        if (len == '0) begin
          r.status  = ST_UNKNOWN;
          phase     = PH_IDLE;
          remaining = '0;
        end else begin
          r.status       = ST_PASSED;
          r.data_byte    = b;
          r.frame_length = len;
          remaining      = len - 10'd1;
          phase          = (remaining == '0) ? PH_TAIL : PH_DATA;
        end
      end
      PH_DATA: begin
        r.status    = ST_PASSED;
        r.data_byte = b;
        if (remaining != '0) remaining = remaining - 10'd1;
        if (remaining == '0) phase = PH_TAIL;
      end
      default: begin
        r.status  = (b == regs.tail_byte) ? ST_COMPLETE : ST_TAILERR;
        phase     = PH_IDLE;
        remaining = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t outcome;
    result_t got;
    if (!rst_ni) begin
      regs      = '0;
      phase     = PH_IDLE;
      remaining = '0;
      byte_outcomes.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_HEAD: regs.head_byte  = cfg_i.data;
          REG_TAIL: regs.tail_byte  = cfg_i.data;
          REG_ROLE: regs.frame_role = cfg_i.data[0];
          default: ;
        endcase
      end
      if (rx_i.valid && rx_i.ready) begin
        outcome = deframe(rx_i.rx_byte);
        case (outcome.status)
          ST_COMPLETE: frames_ok++;
          ST_TAILERR:  tail_errors++;
          ST_UNKNOWN:  unknown_cmds++;
          default: ;
        endcase
        byte_outcomes.push_back(outcome);
      end
      if (res_i.valid && res_i.ready) begin
        if (byte_outcomes.size() == 0) begin
          $error("result transaction with no byte outstanding: status %0d", res_i.status);
          fails++;
        end else begin
          outcome = byte_outcomes.pop_front();
          got.status       = status_e'(res_i.status);
          got.data_byte    = res_i.data_byte;
          got.frame_length = res_i.frame_length;
          if (got.status != outcome.status) begin
            $error("status: expected %0d, got %0d", outcome.status, got.status);
            fails++;
          end
          if (got.data_byte != outcome.data_byte) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", outcome.data_byte,
                   got.data_byte);
            fails++;
          end
          if (got.frame_length != outcome.frame_length) begin
            $error("frame_length: expected %0d, got %0d", outcome.frame_length,
                   got.frame_length);
            fails++;
          end
        end
      end
    end
    fail_count_o   <= fails;
    pending_o      <= byte_outcomes.size();
    frames_ok_o    <= frames_ok;
    tail_errors_o  <= tail_errors;
    unknown_cmds_o <= unknown_cmds;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the UART command frame parser.
// Runs a short directed sequence (reset registers, every status, wrong tail
// equal to head, an unknown host command, register change in
// mid-frame), then random well-formed frames mixed with stray bytes, bad
// commands and bad tails under changing head, tail and role settings. Both
// sides stall at random; a checker beside the block scores every result.
// ----------------------------------------------------------------------------
module tb_top;
  import ucfp_pkg::*;

  localparam int unsigned ItemTarget = 1450;
  localparam int unsigned QuietLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        sink_ready = 1'b0;
  logic        no_gaps = 1'b0;
  logic [7:0]  cur_head = 8'h00;
  logic [7:0]  cur_tail = 8'h00;
  logic        cur_role = 1'b0;
  logic [7:0]  burst[$];
  int unsigned n_bytes = 0;
  int unsigned n_writes = 0;
  int unsigned n_frames = 0;
  int unsigned quiet = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames_ok;
  int unsigned tail_errors;
  int unsigned unknown_cmds;

  ucfp_rx_if  rx_ch ();
  ucfp_cfg_if cfg_ch ();
  ucfp_res_if res_ch ();

  assign res_ch.ready = sink_ready;

  uart_command_frame_parser_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  ucfp_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_i           (rx_ch),
    .cfg_i          (cfg_ch),
    .res_i          (res_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .frames_ok_o    (frames_ok),
    .tail_errors_o  (tail_errors),
    .unknown_cmds_o (unknown_cmds)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    sink_ready <= no_gaps || ($urandom_range(99) >= 21);
  end

  always @(posedge clk_i) begin
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("uart_command_frame_parser_core: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 21) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    n_bytes++;
  endtask

  task automatic send_burst();
    foreach (burst[k]) send_byte(burst[k]);
  endtask

  // drain every outstanding result before touching the registers
  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [7:0] h, input logic [7:0] t, input logic role);
    logic [7:0] vals[3];
    vals = '{h, t, {7'd0, role}};
    for (int k = 0; k < 3; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_reg_e'(k);
      cfg_ch.data  <= vals[k];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
      n_writes++;
    end
    cfg_ch.valid <= 1'b0;
    cur_head = h;
    cur_tail = t;
    cur_role = role;
  endtask

  function automatic logic [7:0] pick_reg_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // favor known commands with short frames; long ones only now and then
  function automatic logic [7:0] pick_command(input logic role);
    logic [7:0]      c;
    logic [LenW-1:0] len;
    c = 8'($urandom_range(255));
    if ($urandom_range(99) < 25) return c;
    repeat (4096) begin
      c   = 8'($urandom_range(255));
      len = role ? device_len(c) : host_len(c);
      if ((role ? (len != 10'd1) : (len != 10'd0)) &&
          (len < 10'd100 || $urandom_range(99) < 6)) return c;
    end
    return c;
  endfunction

  task automatic send_frame();
    logic [7:0]      cmd;
    logic [LenW-1:0] len;
    cmd = pick_command(cur_role);
    len = cur_role ? device_len(cmd) : host_len(cmd);
    send_byte(cur_head);
    send_byte(cmd);
    n_frames++;
    if (len == 10'd0) return;
    repeat (len - 10'd1) send_byte(8'($urandom_range(255)));
    if ($urandom_range(99) < 85) send_byte(cur_tail);
    else send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(4, 1)) begin
      do b = 8'($urandom_range(255)); while (b == cur_head);
      send_byte(b);
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    rx_ch.valid    <= 1'b0;
    rx_ch.rx_byte  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_HEAD;
    cfg_ch.data    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: head and tail zero, host table
    burst = '{8'h55, 8'h00, 8'h30, 8'h00};
    send_burst();
    settle();
    load_regs(8'hA5, 8'h5A, 1'b0);
    // unknown host command, then a wrong tail that equals the head
    burst = '{8'hA5, 8'h77, 8'hA5, 8'h42, 8'hA5, 8'hA5, 8'h5A};
    send_burst();
    settle();
    load_regs(8'hFF, 8'hFF, 1'b1);
    burst = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h12, 8'h00};
    send_burst();
    // change registers in mid-frame, then finish the frame
    settle();
    load_regs(8'h00, 8'h00, 1'b0);
    burst = '{8'hFF, 8'h80, 8'h7F, 8'h00, 8'h00, 8'hD1};
    send_burst();

    while (n_bytes < ItemTarget) begin
      if (n_frames % 20 == 0) begin
        settle();
        load_regs(pick_reg_byte(), pick_reg_byte(), 1'($urandom_range(1)));
      end
      no_gaps = (n_bytes >= 600 && n_bytes < 900);
      if ($urandom_range(99) < 12) send_noise();
      else send_frame();
    end
    no_gaps = 1'b0;
    rx_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Drove %0d bytes and %0d register writes: %0d frames complete, %0d tail errors,",
             n_bytes, n_writes, frames_ok, tail_errors);
    $display("%0d unknown commands, across host and device roles with extreme head/tail.",
             unknown_cmds);
    if (fail_count == 0) begin
      $display("uart_command_frame_parser_core: match");
    end else begin
      $display("uart_command_frame_parser_core: mismatch");
    end
    $finish;
  end

endmodule
